// File: hw/rtl/mie_pkg.sv
// Shared types and codes for the MessagePack item encoder.
package mie_pkg;

	localparam logic [3:0] ACT_NULL   = 4'd0;
	localparam logic [3:0] ACT_BOOL   = 4'd1;
	localparam logic [3:0] ACT_UINT   = 4'd2;
	localparam logic [3:0] ACT_SINT   = 4'd3;
	localparam logic [3:0] ACT_FLOAT  = 4'd4;
	localparam logic [3:0] ACT_STR    = 4'd5;
	localparam logic [3:0] ACT_ARRAY  = 4'd6;
	localparam logic [3:0] ACT_MAP    = 4'd7;
	localparam logic [3:0] ACT_RAW    = 4'd8;

	localparam logic [7:0] TAG_NIL    = 8'hc0;
	localparam logic [7:0] TAG_FALSE  = 8'hc2;
	localparam logic [7:0] TAG_UINT8  = 8'hcc;
	localparam logic [7:0] TAG_UINT16 = 8'hcd;
	localparam logic [7:0] TAG_UINT32 = 8'hce;
	localparam logic [7:0] TAG_UINT64 = 8'hcf;
	localparam logic [7:0] TAG_INT8   = 8'hd0;
	localparam logic [7:0] TAG_INT16  = 8'hd1;
	localparam logic [7:0] TAG_INT32  = 8'hd2;
	localparam logic [7:0] TAG_INT64  = 8'hd3;
	localparam logic [7:0] TAG_FLOAT64 = 8'hcb;
	localparam logic [7:0] TAG_STR8   = 8'hd9;
	localparam logic [7:0] TAG_STR16  = 8'hda;
	localparam logic [7:0] TAG_STR32  = 8'hdb;
	localparam logic [7:0] TAG_ARR16  = 8'hdc;
	localparam logic [7:0] TAG_ARR32  = 8'hdd;
	localparam logic [7:0] TAG_MAP16  = 8'hde;
	localparam logic [7:0] TAG_MAP32  = 8'hdf;
	localparam logic [7:0] FIX_STR    = 8'ha0;
	localparam logic [7:0] FIX_ARRAY  = 8'h90;
	localparam logic [7:0] FIX_MAP    = 8'h80;

	typedef struct packed {
		logic [3:0]  action;
		logic [63:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// One classified item: lead byte, payload byte count, payload left-aligned.
	typedef struct packed {
		logic [7:0]  tag;
		logic [3:0]  nbytes;
		logic [63:0] data;
	} job_t;

endpackage

// File: hw/rtl/mie_classify.sv
// Front end: takes requests, picks the smallest encoding, registers the job.
module mie_classify
	import mie_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  job_valid,
	output job_t  job,
	input  logic  job_full
);

	logic  valid_s1;
	job_t  job_s1;
	job_t  job_d;
	logic  [3:0] act;
	logic  [63:0] v;
	logic  [31:0] len32;
	logic  advance;

	assign act   = item.action;
	assign v     = item.value;
	assign len32 = v[31:0];

	always_comb begin
		logic [7:0] tag;
		logic [3:0] n;
		tag = TAG_NIL;
		n   = 4'd0;
		case (act)
			ACT_BOOL: begin
				tag = TAG_FALSE | {7'd0, v[0]};
			end
			ACT_UINT, ACT_SINT: begin
				if (act == ACT_SINT && v[63]) begin
					if (&v[63:5]) begin
						tag = v[7:0];
					end else if (&v[63:7]) begin
						tag = TAG_INT8;  n = 4'd1;
					end else if (&v[63:15]) begin
						tag = TAG_INT16; n = 4'd2;
					end else if (&v[63:31]) begin
						tag = TAG_INT32; n = 4'd4;
					end else begin
						tag = TAG_INT64; n = 4'd8;
					end
				end else if (v[63:7] == '0) begin
					tag = v[7:0];
				end else if (v[63:8] == '0) begin
					tag = TAG_UINT8;  n = 4'd1;
				end else if (v[63:16] == '0) begin
					tag = TAG_UINT16; n = 4'd2;
				end else if (v[63:32] == '0) begin
					tag = TAG_UINT32; n = 4'd4;
				end else begin
					tag = TAG_UINT64; n = 4'd8;
				end
			end
			ACT_FLOAT: begin
				tag = TAG_FLOAT64; n = 4'd8;
			end
			ACT_STR: begin
				if (len32[31:5] == '0) begin
					tag = FIX_STR | {3'd0, len32[4:0]};
				end else if (len32[31:8] == '0) begin
					tag = TAG_STR8;  n = 4'd1;
				end else if (len32[31:16] == '0) begin
					tag = TAG_STR16; n = 4'd2;
				end else begin
					tag = TAG_STR32; n = 4'd4;
				end
			end
			ACT_ARRAY, ACT_MAP: begin
				if (len32[31:4] == '0) begin
					tag = ((act == ACT_MAP) ? FIX_MAP : FIX_ARRAY) | {4'd0, len32[3:0]};
				end else if (len32[31:16] == '0) begin
					tag = (act == ACT_MAP) ? TAG_MAP16 : TAG_ARR16; n = 4'd2;
				end else begin
					tag = (act == ACT_MAP) ? TAG_MAP32 : TAG_ARR32; n = 4'd4;
				end
			end
			ACT_RAW: begin
				tag = v[7:0];
			end
			default: begin
				tag = TAG_NIL;
			end
		endcase
		job_d.tag    = tag;
		job_d.nbytes = n;
		// left-align payload so the back end always shifts out the top byte
		case (n)
			4'd1:    job_d.data = {v[7:0], 56'd0};
			4'd2:    job_d.data = {v[15:0], 48'd0};
			4'd4:    job_d.data = {v[31:0], 32'd0};
			4'd8:    job_d.data = v;
			default: job_d.data = '0;
		endcase
	end

	assign advance   = !valid_s1 || !job_full;
	assign full      = !advance;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			job_s1 <= job_d;
		end
	end

endmodule

// File: hw/rtl/mie_queue.sv
// Small job queue between the classifier and the serializer.
module mie_queue
	import mie_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  job_t wr_job,
	output logic q_full,
	output logic rd_valid,
	output job_t rd_job,
	input  logic rd_take
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full   = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rptr_q];
	assign do_wr    = wr_valid && !q_full;
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule

// File: hw/rtl/mie_serializer.sv
// Back end: shifts out the lead byte and the payload bytes of each job.
module mie_serializer
	import mie_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic        active_q;
	logic        sent_tag_q;
	logic [3:0]  cnt_q;
	logic [7:0]  tag_q;
	logic [63:0] data_q;
	logic        cur_last;
	logic        popped;

	assign cur_last        = sent_tag_q ? (cnt_q == 4'd1) : (cnt_q == 4'd0);
	assign popped          = pop && active_q;
	assign job_take        = job_valid && (!active_q || (popped && cur_last));
	assign empty           = !active_q;
	assign result.out_byte = sent_tag_q ? data_q[63:56] : tag_q;
	assign result.last     = cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			sent_tag_q <= 1'b0;
			cnt_q      <= '0;
		end else if (job_take) begin
			active_q   <= 1'b1;
			sent_tag_q <= 1'b0;
			cnt_q      <= job.nbytes;
		end else if (popped) begin
			if (cur_last) begin
				active_q <= 1'b0;
			end else if (!sent_tag_q) begin
				sent_tag_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			tag_q  <= job.tag;
			data_q <= job.data;
		end else if (popped && sent_tag_q) begin
			data_q <= {data_q[55:0], 8'd0};
		end
	end

endmodule

// File: hw/rtl/messagepack_item_encoder_core.sv
// MessagePack item encoder: one request in, its encoded bytes out.
//
// Input channel: a request (action, value) is taken on a rising edge with push
// high and full low. Result channel: while empty is low, result holds the next
// encoded byte and its last flag; pop high on an edge with empty low takes it.
// Each request yields 1 to 9 bytes, the final one marked last.
//
// When the back end is idle, a taken request passes the classifier register
// and the job queue before the serializer loads it. The classifier registers
// the chosen form, a QUEUE_DEPTH-entry job queue sits between it and the
// serializer. The result side gives one byte per cycle while pop stays high,
// and the next job is loaded on the edge that pops the last byte, so
// single-byte requests stream at one per cycle. The request side keeps
// accepting until the job queue and the classifier register are both full.
// Reset clears the classifier stage, the queue and the serializer; nothing else
// is held between requests. When the receiver stalls, the current byte holds
// and the queue fills, then full rises.
module messagepack_item_encoder_core
	import mie_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic cls_valid;
	job_t cls_job;
	logic q_full;
	logic q_valid;
	job_t q_job;
	logic q_take;

	mie_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (cls_valid),
		.job       (cls_job),
		.job_full  (q_full)
	);

	mie_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cls_valid),
		.wr_job   (cls_job),
		.q_full   (q_full),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.rd_take  (q_take)
	);

	mie_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_job),
		.job_take  (q_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: tb/sv/mie_byte_checker.sv
// Scoreboard for the MessagePack item encoder: predicts the byte stream and checks it.
`timescale 1ns / 100ps

module mie_byte_checker
	import mie_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      mismatches,
	output int      bytes_due
);

	localparam logic [7:0] TAG_TRUE = 8'hc3;

	result_t    expected_bytes[$];
	logic [7:0] frame[$];

	function automatic void frame_add(input logic [7:0] b);
		frame.insert(frame.size(), b);
	endfunction

	function automatic void frame_tagged(input logic [7:0] tag, input logic [63:0] v,
		input int n);
		int i;
		frame_add(tag);
		for (i = n - 1; i >= 0; i--)
			frame_add(v[8 * i +: 8]);
	endfunction

	function automatic void frame_uint(input logic [63:0] u);
		if (u <= 64'h7f)
			frame_add(u[7:0]);
		else if (u <= 64'hff)
			frame_tagged(TAG_UINT8, u, 1);
		else if (u <= 64'hffff)
			frame_tagged(TAG_UINT16, u, 2);
		else if (u <= 64'hffff_ffff)
			frame_tagged(TAG_UINT32, u, 4);
		else
			frame_tagged(TAG_UINT64, u, 8);
	endfunction

	function automatic void frame_sint(input logic [63:0] s);
		if (!s[63])
			frame_uint(s);
		else if (s >= 64'hffff_ffff_ffff_ffe0)
			frame_add(s[7:0]);
		else if (s >= 64'hffff_ffff_ffff_ff80)
			frame_tagged(TAG_INT8, s, 1);
		else if (s >= 64'hffff_ffff_ffff_8000)
			frame_tagged(TAG_INT16, s, 2);
		else if (s >= 64'hffff_ffff_8000_0000)
			frame_tagged(TAG_INT32, s, 4);
		else
			frame_tagged(TAG_INT64, s, 8);
	endfunction

	// array and map headers: fix form up to 15, then 16- and 32-bit forms
	function automatic void frame_header(input logic [31:0] n, input logic [7:0] fix,
		input logic [7:0] tag16, input logic [7:0] tag32);
		if (n <= 32'd15)
			frame_add(fix | n[7:0]);
		else if (n <= 32'hffff)
			frame_tagged(tag16, {32'd0, n}, 2);
		else
			frame_tagged(tag32, {32'd0, n}, 4);
	endfunction

	function automatic void predict_item(input item_t it);
		logic [31:0] len;
		result_t     r;
		int          i;
		len = it.value[31:0];
		frame.delete();
		case (it.action)
			ACT_BOOL:  frame_add(it.value[0] ? TAG_TRUE : TAG_FALSE);
			ACT_UINT:  frame_uint(it.value);
			ACT_SINT:  frame_sint(it.value);
			ACT_FLOAT: frame_tagged(TAG_FLOAT64, it.value, 8);
			ACT_STR: begin
				if (len <= 32'd31)
					frame_add(FIX_STR | len[7:0]);
				else if (len <= 32'hff)
					frame_tagged(TAG_STR8, {32'd0, len}, 1);
				else if (len <= 32'hffff)
					frame_tagged(TAG_STR16, {32'd0, len}, 2);
				else
					frame_tagged(TAG_STR32, {32'd0, len}, 4);
			end
			ACT_ARRAY: frame_header(len, FIX_ARRAY, TAG_ARR16, TAG_ARR32);
			ACT_MAP:   frame_header(len, FIX_MAP, TAG_MAP16, TAG_MAP32);
			ACT_RAW:   frame_add(it.value[7:0]);
			default:   frame_add(TAG_NIL);	// null and unused action codes
		endcase
		for (i = 0; i < frame.size(); i++) begin
			r.out_byte = frame[i];
			r.last     = (i == frame.size() - 1);
			expected_bytes.insert(expected_bytes.size(), r);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (push && !full)
				predict_item(item);
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t: unexpected byte: expected none, actual %02h last %0b",
						$time, result.out_byte, result.last);
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte) begin
						mismatches = mismatches + 1;
						$display("%0t: out_byte mismatch: expected %02h, actual %02h",
							$time, want.out_byte, result.out_byte);
					end
					if (result.last !== want.last) begin
						mismatches = mismatches + 1;
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, result.last);
					end
				end
			end
			bytes_due = expected_bytes.size();
		end
	end

endmodule

// File: tb/sv/messagepack_item_encoder_core_tb.sv
// Stimulus and verdict for the MessagePack item encoder core.
`timescale 1ns / 100ps

module messagepack_item_encoder_core_tb;
	import mie_pkg::*;

	localparam logic [3:0] ACT_SPARE_FIRST = 4'd9;
	localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;
	localparam int         RANDOM_ITEMS    = 410;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    pop    = 1'b0;
	item_t   item   = '0;
	logic    full;
	logic    empty;
	result_t result;

	int mismatches;
	int bytes_due;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	messagepack_item_encoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	mie_byte_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	// receiver: stretches of steady popping, random popping and hard stalls
	always @(negedge clk) begin
		logic take;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(4, 40);
		end
		stall_left--;
		case (stall_mode)
			0, 1:    take = 1'b1;
			2:       take = 1'($urandom_range(0, 1));
			default: take = 1'b0;
		endcase
		pop <= take;
	end

	// one request, sent in bursts with random gaps in between
	task automatic send_item(input logic [3:0] act, input logic [63:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push        <= 1'b1;
		item.action <= act;
		item.value  <= val;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(negedge clk); while (bytes_due != 0);
		burst_left = 0;
	endtask

	// values clustered around the encoding boundaries, plus plain noise
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          w;
		v = {$urandom, $urandom};
		w = $urandom_range(1, 64);
		case ($urandom_range(0, 5))
			0:       rand_value = v;
			1:       rand_value = v >> (64 - w);
			2:       rand_value = 64'd1 << (w - 1);
			3:       rand_value = (64'd1 << (w - 1)) - 64'd1;
			4:       rand_value = ~(v >> (64 - w));
			default: rand_value = -(64'd1 << (w - 1));
		endcase
	endfunction

	function automatic logic [3:0] rand_action();
		if ($urandom_range(0, 24) == 0)
			rand_action = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		else
			rand_action = 4'($urandom_range(ACT_NULL, ACT_RAW));
	endfunction

	initial begin
		#10_000_000;
		$display("messagepack_item_encoder_core_tb: errors");
		$finish;
	end

	initial begin
		int          sent;
		int          i;
		bit          mid_drain;
		logic [3:0]  act;
		logic [63:0] val;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(ACT_NULL, 64'd0);
		send_item(ACT_BOOL, 64'hffff_ffff_ffff_fffe);	// only bit 0 counts
		send_item(ACT_BOOL, 64'd1);
		send_item(ACT_UINT, 64'h7f);
		send_item(ACT_UINT, 64'h80);
		send_item(ACT_UINT, 64'h100);
		send_item(ACT_UINT, 64'h1_0000);
		send_item(ACT_UINT, 64'hffff_ffff);
		send_item(ACT_UINT, 64'hffff_ffff_ffff_ffff);
		send_item(ACT_SINT, 64'd5);
		send_item(ACT_SINT, 64'hffff_ffff_ffff_ffe0);
		send_item(ACT_SINT, 64'hffff_ffff_ffff_ffdf);
		send_item(ACT_SINT, 64'hffff_ffff_ffff_ff7f);
		send_item(ACT_SINT, 64'hffff_ffff_ffff_7fff);
		send_item(ACT_SINT, 64'hffff_ffff_7fff_ffff);
		send_item(ACT_SINT, 64'h8000_0000_0000_0000);
		send_item(ACT_FLOAT, 64'h3ff0_0000_0000_0001);
		send_item(ACT_STR, 64'd31);
		send_item(ACT_STR, 64'd32);
		send_item(ACT_STR, 64'h100);
		send_item(ACT_STR, 64'h1_0001_0000);	// length cut to 32 bits
		send_item(ACT_ARRAY, 64'd15);
		send_item(ACT_ARRAY, 64'hffff_ffff_0000_0010);
		send_item(ACT_MAP, 64'h1_0000_0000);
		send_item(ACT_MAP, 64'h1_0000);
		send_item(ACT_RAW, 64'hffff_ffff_ffff_ff5a);
		send_item(ACT_SPARE_FIRST, 64'd0);
		send_item(ACT_SPARE_LAST, 64'hffff_ffff_ffff_ffff);
		wait_drained();

		sent      = 0;
		mid_drain = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			act = rand_action();
			val = rand_value();
			send_item(act, val);
			sent++;
			// short strings carry their body bytes right behind the header
			if (act == ACT_STR && val[31:0] <= 32'd12)
				for (i = 0; i < val[31:0]; i++) begin
					send_item(ACT_RAW, {$urandom, $urandom});
					sent++;
				end
			if (!mid_drain && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				mid_drain = 1'b1;
			end
		end

		push <= 1'b0;
		while (bytes_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("messagepack_item_encoder_core_tb: clean");
		else
			$display("messagepack_item_encoder_core_tb: errors");
		$finish;
	end

endmodule
